FILE: hw/rtl/gdq_pkg.sv
// shared constants and types for the group-dequant dot product unit
`timescale 1ns / 1ps
`default_nettype none

package gdq_pkg;

  localparam int LANES_DEF  = 4;
  localparam int ACC_W_DEF  = 48;

  localparam int ACT_W      = 16;
  localparam int WGT_W      = 8;
  localparam int SCALE_W    = 16;
  localparam int PROD_W     = ACT_W + WGT_W;
  localparam int OUT_W      = 48;
  // bias product is q.15, shift up to q.27
  localparam int FRAC_ALIGN = 12;

  typedef struct packed {
    logic valid;
    logic last;
  } gdq_ctrl_t;

  typedef struct packed {
    logic signed [SCALE_W-1:0] group_scale;
    logic signed [WGT_W-1:0]   bias_weight;
    logic signed [SCALE_W-1:0] bias_scale;
  } gdq_side_t;

endpackage

`default_nettype wire

FILE: hw/rtl/gdq_if.sv
// valid/ready channel interfaces for input items and results
`timescale 1ns / 1ps
`default_nettype none

interface gdq_in_if import gdq_pkg::*; #(
  parameter int LANES = LANES_DEF
) ();
  logic                              valid;
  logic                              ready;
  logic [LANES-1:0][ACT_W-1:0]       activation;
  logic [LANES-1:0][WGT_W-1:0]       weight;
  logic signed [SCALE_W-1:0]         group_scale;
  logic signed [WGT_W-1:0]           bias_weight;
  logic signed [SCALE_W-1:0]         bias_scale;
  logic                              last;

  modport source (
    output valid, activation, weight, group_scale, bias_weight, bias_scale, last,
    input  ready
  );
  modport sink (
    input  valid, activation, weight, group_scale, bias_weight, bias_scale, last,
    output ready
  );
endinterface

interface gdq_out_if import gdq_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] sum_out;

  modport source (output valid, sum_out, input ready);
  modport sink (input valid, sum_out, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/gdq_lane.sv
// one lane: registered activation times weight product
`timescale 1ns / 1ps
`default_nettype none

module gdq_lane import gdq_pkg::*; (
  input  logic                     clk,
  input  logic                     en,
  input  logic signed [ACT_W-1:0]  act,
  input  logic signed [WGT_W-1:0]  wgt,
  output logic signed [PROD_W-1:0] prod_r
);

  logic signed [PROD_W-1:0] prod_nxt;

  assign prod_nxt = act * wgt;

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= prod_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/gdq_merge.sv
// lane sum tree, group scale multiply and bias product
`timescale 1ns / 1ps
`default_nettype none

module gdq_merge import gdq_pkg::*; #(
  parameter int LANES = LANES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic [LANES-1:0][PROD_W-1:0]  prod,
  input  gdq_ctrl_t                     ctrl_in,
  input  gdq_side_t                     side_in,
  output logic signed [PROD_W+$clog2(LANES)+SCALE_W-1:0] term_r,
  output logic signed [PROD_W-1:0]      bias_prod_r,
  output gdq_ctrl_t                     ctrl_r
);

  localparam int SUM_W  = PROD_W + $clog2(LANES);
  localparam int TERM_W = SUM_W + SCALE_W;
  localparam int P      = 1 << $clog2(LANES);

  logic signed [SUM_W-1:0]  leaf [P];
  logic signed [SUM_W-1:0]  node [2*P-1];
  logic signed [SUM_W-1:0]  sum_r;
  gdq_side_t                side_r;
  gdq_ctrl_t                ctrl2_r;
  logic signed [TERM_W-1:0] term_nxt;
  logic signed [PROD_W-1:0] bias_prod_nxt;

  // pad the tree to a power of two with zero leaves
  for (genvar g = 0; g < P; g++) begin : g_leaf
    if (g < LANES) begin : g_used
      assign leaf[g] = SUM_W'(signed'(prod[g]));
    end else begin : g_pad
      assign leaf[g] = '0;
    end
  end

  always_comb begin
    for (int i = 0; i < P; i++) begin
      node[P-1+i] = leaf[i];
    end
    for (int i = P - 2; i >= 0; i--) begin
      node[i] = node[2*i+1] + node[2*i+2];
    end
  end

  assign term_nxt      = sum_r * side_r.group_scale;
  assign bias_prod_nxt = side_r.bias_weight * side_r.bias_scale;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl2_r <= '0;
      ctrl_r  <= '0;
    end else if (en) begin
      ctrl2_r <= ctrl_in;
      ctrl_r  <= ctrl2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sum_r       <= node[0];
      side_r      <= side_in;
      term_r      <= term_nxt;
      bias_prod_r <= bias_prod_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/gdq_acc.sv
// saturating accumulator, bias add, output clamp and result register
`timescale 1ns / 1ps
`default_nettype none

module gdq_acc import gdq_pkg::*; #(
  parameter int ACC_W  = ACC_W_DEF,
  parameter int TERM_W = PROD_W + SCALE_W
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  gdq_ctrl_t                ctrl_in,
  input  logic signed [TERM_W-1:0] term,
  input  logic signed [PROD_W-1:0] bias_prod,
  input  logic                     bias_en,
  input  logic                     out_ready,
  output logic                     en,
  output logic                     out_valid_r,
  output logic [OUT_W-1:0]         sum_out_r
);

  localparam int EW  = ((ACC_W > TERM_W) ? ACC_W : TERM_W) + 1;
  localparam int BW  = PROD_W + FRAC_ALIGN;
  localparam int BEW = ((ACC_W > BW) ? ACC_W : BW) + 1;

  logic signed [ACC_W-1:0] acc_r, acc_nxt;
  logic signed [ACC_W-1:0] fin_r;
  logic signed [ACC_W-1:0] bsum_r, bsum_nxt;
  logic signed [PROD_W-1:0] bias4_r;
  logic                    s4_v_r, s5_v_r;
  logic                    stall;

  logic signed [EW-1:0]    acc_sum;
  logic                    acc_ok;
  logic signed [BEW-1:0]   bias_ext, b_sum;
  logic                    b_ok;
  logic [OUT_W-1:0]        out_nxt;

  // accumulate with saturation to the accumulator range
  assign acc_sum = EW'(acc_r) + EW'(term);
  assign acc_ok  = (acc_sum[EW-1:ACC_W-1] == '0) || (acc_sum[EW-1:ACC_W-1] == '1);
  assign acc_nxt = acc_ok ? acc_sum[ACC_W-1:0]
                          : {acc_sum[EW-1], {(ACC_W-1){~acc_sum[EW-1]}}};

  // bias at 27 fraction bits, then the same saturation
  assign bias_ext = BEW'(bias4_r) <<< FRAC_ALIGN;
  assign b_sum    = BEW'(fin_r) + (bias_en ? bias_ext : BEW'(0));
  assign b_ok     = (b_sum[BEW-1:ACC_W-1] == '0) || (b_sum[BEW-1:ACC_W-1] == '1);
  assign bsum_nxt = b_ok ? b_sum[ACC_W-1:0] : {b_sum[BEW-1], {(ACC_W-1){~b_sum[BEW-1]}}};

  if (ACC_W > OUT_W) begin : g_clamp
    logic o_ok;
    assign o_ok    = (bsum_r[ACC_W-1:OUT_W-1] == '0) || (bsum_r[ACC_W-1:OUT_W-1] == '1);
    assign out_nxt = o_ok ? bsum_r[OUT_W-1:0]
                          : {bsum_r[ACC_W-1], {(OUT_W-1){~bsum_r[ACC_W-1]}}};
  end else begin : g_extend
    assign out_nxt = OUT_W'(bsum_r);
  end

  // only a finished result behind one blocked at the output holds the pipe
  assign stall = s5_v_r && out_valid_r && !out_ready;
  assign en    = !stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r       <= '0;
      s4_v_r      <= 1'b0;
      s5_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (en) begin
        if (ctrl_in.valid) begin
          acc_r <= ctrl_in.last ? '0 : acc_nxt;
        end
        s4_v_r <= ctrl_in.valid && ctrl_in.last;
        s5_v_r <= s4_v_r;
      end
      if (en && s5_v_r) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (ctrl_in.valid && ctrl_in.last) begin
        fin_r <= acc_nxt;
      end
      bias4_r <= bias_prod;
      bsum_r  <= bsum_nxt;
      if (s5_v_r) begin
        sum_out_r <= out_nxt;
      end
    end
  end

`ifndef SYNTHESIS
  a_acc_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (en && ctrl_in.valid && ctrl_in.last) |=> (acc_r == '0))
    else $error("accumulator not cleared after last transaction");

  a_no_bias: assert property (@(posedge clk) disable iff (!rst_n)
    (en && s4_v_r && !bias_en) |=> (bsum_r == $past(fin_r)))
    else $error("result changed with bias disabled");

  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s5_v_r && en))
    else $error("result raised without a finished sum");
`endif

endmodule

`default_nettype wire

FILE: hw/rtl/int8_group_dequant_dot_product_unit.sv
// top level of the group-dequantized int8 dot product unit
//
//  channel  | dir | handshake            | payload
//  ---------+-----+----------------------+---------------------------------------------
//  in_ch    | in  | valid/ready          | activation[], weight[], group_scale,
//           |     |                      | bias_weight, bias_scale, last
//  out_ch   | out | valid/ready          | sum_out (48b signed, 27 fraction bits)
//  cfg      | in  | cfg_wr_en, no wait   | cfg_wr_data = bias_enable
//
//  one transaction per cycle while in_ch.ready is high
//  result registers in order: lane multiply, sum tree, scale multiply, accumulate, bias add, out reg
//  input stalls only while a result waits unaccepted and another finished one is behind it
//  synchronous reset clears accumulator, bias_enable and all stage valids
//  no clearing pass: the unit takes transactions right after reset
`timescale 1ns / 1ps
`default_nettype none

module int8_group_dequant_dot_product_unit import gdq_pkg::*; #(
  parameter int LANES     = LANES_DEF,
  parameter int ACC_WIDTH = ACC_W_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,
  gdq_in_if.sink      in_ch,
  gdq_out_if.source   out_ch
);

  localparam int TERM_W = PROD_W + $clog2(LANES) + SCALE_W;

  logic                           en;
  logic                           bias_en_r;
  gdq_ctrl_t                      s1_ctrl_r, s1_ctrl_nxt;
  gdq_side_t                      s1_side_r, s1_side_nxt;
  gdq_ctrl_t                      s3_ctrl;
  logic [LANES-1:0][PROD_W-1:0]   prod;
  logic signed [TERM_W-1:0]       term;
  logic signed [PROD_W-1:0]       bias_prod;
  logic                           out_valid;
  logic [OUT_W-1:0]               sum_out;

  // ready drops only when the output holds a blocked result and another finished one is behind it
  assign in_ch.ready = en;

  // bias enable register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bias_en_r <= 1'b0;
    end else if (cfg_wr_en) begin
      bias_en_r <= cfg_wr_data;
    end
  end

  // stage 1 side band travels with the lane products
  assign s1_ctrl_nxt = '{valid: in_ch.valid, last: in_ch.last};
  assign s1_side_nxt = '{group_scale: in_ch.group_scale,
                         bias_weight: in_ch.bias_weight,
                         bias_scale:  in_ch.bias_scale};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_ctrl_r <= '0;
    end else if (en) begin
      s1_ctrl_r <= s1_ctrl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_side_r <= s1_side_nxt;
    end
  end

  // lane multipliers, one per element of the transaction
  for (genvar g = 0; g < LANES; g++) begin : g_lane
    gdq_lane u_lane (
      .clk    (clk),
      .en     (en),
      .act    (in_ch.activation[g]),
      .wgt    (in_ch.weight[g]),
      .prod_r (prod[g])
    );
  end

  // sum tree, then group scale and bias products
  gdq_merge #(
    .LANES (LANES)
  ) u_merge (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (en),
    .prod        (prod),
    .ctrl_in     (s1_ctrl_r),
    .side_in     (s1_side_r),
    .term_r      (term),
    .bias_prod_r (bias_prod),
    .ctrl_r      (s3_ctrl)
  );

  // accumulate, bias, clamp and hold the result
  gdq_acc #(
    .ACC_W  (ACC_WIDTH),
    .TERM_W (TERM_W)
  ) u_acc (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctrl_in     (s3_ctrl),
    .term        (term),
    .bias_prod   (bias_prod),
    .bias_en     (bias_en_r),
    .out_ready   (out_ch.ready),
    .en          (en),
    .out_valid_r (out_valid),
    .sum_out_r   (sum_out)
  );

  assign out_ch.valid   = out_valid;
  assign out_ch.sum_out = sum_out;

endmodule

`default_nettype wire
